@@ src/eller_maze_row_generator_unit_macros.svh @@
// Assertion macros shared by the checker of the maze row generator.
`ifndef ELLER_MAZE_ROW_GENERATOR_UNIT_MACROS_SVH
`define ELLER_MAZE_ROW_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EMRG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define EMRG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/emrg_pkg.sv @@
// Shared constants and types of the maze row generator.
`timescale 1ns / 1ps
`default_nettype none

package emrg_pkg;

  localparam int MAX_WIDTH  = 16;
  localparam int LABEL_BITS = 24;
  localparam int CELL_BITS  = $clog2(MAX_WIDTH);
  localparam int CNT_BITS   = $clog2(MAX_WIDTH + 1);

  localparam int RIGHT_BITS    = 15;
  localparam int BOTTOM_BITS   = 16;
  localparam int ROW_BITS      = 16;
  localparam int WIDTH_BITS    = 5;
  localparam int HEIGHT_BITS   = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_MAZE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAZE_HEIGHT = 1'd1;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 5'd16;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd16;

  typedef logic [LABEL_BITS-1:0] label_t;
  typedef logic [CELL_BITS-1:0]  cell_t;

  typedef struct packed {
    logic [RIGHT_BITS-1:0]  right_draws;
    logic [BOTTOM_BITS-1:0] bottom_draws;
  } in_item_t;

  typedef struct packed {
    logic [RIGHT_BITS-1:0]  right_walls;
    logic [BOTTOM_BITS-1:0] bottom_walls;
    logic [ROW_BITS-1:0]    row_number;
    logic                   last_row;
  } out_item_t;

  typedef struct packed {
    logic [RIGHT_BITS-1:0]  right_draws;
    logic [BOTTOM_BITS-1:0] bottom_draws;
    logic [CNT_BITS-1:0]    width;
    logic                   last;
  } row_job_t;

  typedef struct packed {
    logic [RIGHT_BITS-1:0]  right_walls;
    logic [BOTTOM_BITS-1:0] bottom_walls;
  } row_res_t;

  typedef struct packed {
    logic                 we;
    cell_t                waddr;
    label_t               wdata;
    cell_t                raddr;
    logic [MAX_WIDTH-1:0] clr_mask;
  } lbl_req_t;

endpackage

`default_nettype wire

@@ src/emrg_label_ram.sv @@
// Label memory: one write and one registered read per cycle, with per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module emrg_label_ram (
  input  wire               clk,
  input  wire               rst,
  input  emrg_pkg::lbl_req_t req,
  output emrg_pkg::label_t   rdata
);
  import emrg_pkg::*;

  label_t               mem [MAX_WIDTH];
  logic [MAX_WIDTH-1:0] valid;
  label_t               rd_q;
  logic                 rvalid_q;
  logic                 same_addr;
  logic [MAX_WIDTH-1:0] wr_onehot;

  assign same_addr = req.we && (req.waddr == req.raddr);
  assign wr_onehot = req.we ? (MAX_WIDTH'(1) << req.waddr) : '0;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (same_addr) begin
      rd_q <= req.wdata;
    end else begin
      rd_q <= mem[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      valid    <= (valid & ~req.clr_mask) | wr_onehot;
      rvalid_q <= same_addr | valid[req.raddr];
    end
  end

  assign rdata = rvalid_q ? rd_q : '0;

endmodule

`default_nettype wire

@@ src/emrg_row_seq.sv @@
// Row sequencer: label fill, set merging, bottom wall and hole passes over the label memory.
`timescale 1ns / 1ps
`default_nettype none

module emrg_row_seq (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  emrg_pkg::row_job_t job,
  input  wire                res_ready,
  output logic               idle,
  output logic               res_load,
  output emrg_pkg::row_res_t res,
  output emrg_pkg::lbl_req_t lbl_req,
  input  emrg_pkg::label_t   lbl_rdata
);
  import emrg_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FILL   = 4'd1;
  localparam logic [3:0] S_MKEY   = 4'd2;
  localparam logic [3:0] S_MLEFT  = 4'd3;
  localparam logic [3:0] S_MEVAL  = 4'd4;
  localparam logic [3:0] S_MSWEEP = 4'd5;
  localparam logic [3:0] S_BKEY   = 4'd6;
  localparam logic [3:0] S_BSCAN  = 4'd7;
  localparam logic [3:0] S_HKEY   = 4'd8;
  localparam logic [3:0] S_HSCAN  = 4'd9;
  localparam logic [3:0] S_CLR    = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  function automatic label_t label_inc(input label_t v);
    label_t n;
    n = v + 1'b1;
    if (n == '0) begin
      n = LABEL_BITS'(1);
    end
    return n;
  endfunction

  logic [3:0]           state, state_next;
  logic [CNT_BITS-1:0]  cnt, cnt_next;
  cell_t                cur, cur_next;
  logic                 pend, pend_next;
  cell_t                paddr, paddr_next;
  logic                 pkey, pkey_next;
  label_t               left, left_next;
  label_t               rlab, rlab_next;
  logic                 other, other_next;
  logic                 mlast, mlast_next;
  logic [MAX_WIDTH-1:0] rw, rw_next;
  logic [MAX_WIDTH-1:0] bw, bw_next;
  logic [MAX_WIDTH-1:0] rdraw, rdraw_next;
  logic [MAX_WIDTH-1:0] bdraw, bdraw_next;
  logic [CNT_BITS-1:0]  w, w_next;
  logic                 last, last_next;
  label_t               next_label, next_label_next;

  cell_t                wm1;
  logic                 last_step;
  logic                 cur_last;
  logic                 more;
  logic [MAX_WIDTH:0]   wmask_wide;
  logic [MAX_WIDTH-1:0] wmask;
  logic                 pass_end;
  logic                 scan_adv;
  logic                 merge;
  logic                 match;

  assign wm1        = CELL_BITS'(w - CNT_BITS'(1));
  assign last_step  = (CNT_BITS'(cur) + CNT_BITS'(2)) == w;
  assign cur_last   = (cur == wm1);
  assign more       = (cnt < w);
  assign wmask_wide = ((MAX_WIDTH + 1)'(1) << w) - 1'b1;
  assign wmask      = wmask_wide[MAX_WIDTH-1:0];

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    cur_next        = cur;
    left_next       = left;
    rlab_next       = rlab;
    other_next      = other;
    mlast_next      = mlast;
    rw_next         = rw;
    bw_next         = bw;
    rdraw_next      = rdraw;
    bdraw_next      = bdraw;
    w_next          = w;
    last_next       = last;
    next_label_next = next_label;
    pend_next       = 1'b0;
    paddr_next      = '0;
    pkey_next       = 1'b0;
    pass_end        = 1'b0;
    scan_adv        = 1'b0;
    merge           = 1'b0;
    match           = 1'b0;
    res_load        = 1'b0;
    lbl_req         = '{we: 1'b0, waddr: paddr, wdata: left, raddr: '0, clr_mask: '0};

    case (state)
      S_IDLE: begin
        if (start) begin
          rdraw_next = MAX_WIDTH'(job.right_draws);
          bdraw_next = MAX_WIDTH'(job.bottom_draws);
          w_next     = job.width;
          last_next  = job.last;
          rw_next    = '0;
          bw_next    = '0;
          cnt_next   = '0;
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        if (more) begin
          pend_next  = 1'b1;
          paddr_next = CELL_BITS'(cnt);
          cnt_next   = cnt + 1'b1;
        end
        if (pend) begin
          if (lbl_rdata == '0) begin
            lbl_req.we      = 1'b1;
            lbl_req.wdata   = next_label;
            next_label_next = label_inc(next_label);
          end
          if (paddr == wm1) begin
            mlast_next = 1'b0;
            state_next = S_MKEY;
          end
        end
      end
      S_MKEY: begin
        pend_next  = 1'b1;
        paddr_next = '0;
        cur_next   = '0;
        state_next = S_MLEFT;
      end
      S_MLEFT: begin
        left_next = lbl_rdata;
        if (w == CNT_BITS'(1)) begin
          pass_end = 1'b1;
        end else begin
          pend_next  = 1'b1;
          paddr_next = CELL_BITS'(1);
          state_next = S_MEVAL;
        end
      end
      S_MEVAL: begin
        if (mlast) begin
          merge = (left != lbl_rdata);
        end else begin
          merge = !(rdraw[cur] || (left == lbl_rdata));
        end
        if (merge) begin
          rw_next[cur] = 1'b0;
          rlab_next    = lbl_rdata;
          cnt_next     = '0;
          state_next   = S_MSWEEP;
        end else begin
          if (!mlast) begin
            rw_next[cur] = 1'b1;
          end
          left_next = lbl_rdata;
          pass_end  = last_step;
        end
      end
      S_MSWEEP: begin
        if (more) begin
          pend_next  = 1'b1;
          paddr_next = CELL_BITS'(cnt);
          cnt_next   = cnt + 1'b1;
        end
        if (pend) begin
          if (lbl_rdata == rlab) begin
            lbl_req.we = 1'b1;
          end
          if (paddr == wm1) begin
            pass_end = last_step;
          end
        end
      end
      S_BKEY: begin
        if (bdraw[cur]) begin
          pend_next  = 1'b1;
          pkey_next  = 1'b1;
          paddr_next = cur;
          other_next = 1'b0;
          cnt_next   = '0;
          state_next = S_BSCAN;
        end else begin
          scan_adv = 1'b1;
        end
      end
      S_BSCAN: begin
        if (more) begin
          pend_next  = 1'b1;
          paddr_next = CELL_BITS'(cnt);
          cnt_next   = cnt + 1'b1;
        end
        if (pend) begin
          if (pkey) begin
            rlab_next = lbl_rdata;
          end else begin
            match = (lbl_rdata == rlab) && (paddr != cur);
            if (paddr == wm1) begin
              bw_next[cur] = other | match;
              scan_adv     = 1'b1;
            end else begin
              other_next = other | match;
            end
          end
        end
      end
      S_HKEY: begin
        if (bw[cur]) begin
          pend_next  = 1'b1;
          pkey_next  = 1'b1;
          paddr_next = cur;
          other_next = 1'b0;
          cnt_next   = '0;
          state_next = S_HSCAN;
        end else begin
          scan_adv = 1'b1;
        end
      end
      S_HSCAN: begin
        if (more) begin
          pend_next  = 1'b1;
          paddr_next = CELL_BITS'(cnt);
          cnt_next   = cnt + 1'b1;
        end
        if (pend) begin
          if (pkey) begin
            rlab_next = lbl_rdata;
          end else begin
            match = (lbl_rdata == rlab) && !bw[paddr];
            if (paddr == wm1) begin
              if (!(other | match)) begin
                bw_next[cur] = 1'b0;
              end
              scan_adv = 1'b1;
            end else begin
              other_next = other | match;
            end
          end
        end
      end
      S_CLR: begin
        if (last) begin
          lbl_req.clr_mask = '1;
          next_label_next  = LABEL_BITS'(1);
          bw_next          = wmask;
        end else begin
          lbl_req.clr_mask = bw;
        end
        state_next = S_FIN;
      end
      S_FIN: begin
        if (res_ready) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (state == S_MEVAL || state == S_MSWEEP) begin
      if ((state == S_MEVAL && !merge) || (state == S_MSWEEP && pend && paddr == wm1)) begin
        if (!last_step) begin
          cur_next   = CELL_BITS'(cur + 1'b1);
          pend_next  = 1'b1;
          paddr_next = CELL_BITS'(CNT_BITS'(cur) + CNT_BITS'(2));
          state_next = S_MEVAL;
        end
      end
    end

    if (pass_end) begin
      if (mlast) begin
        state_next = S_CLR;
      end else if (last) begin
        mlast_next = 1'b1;
        state_next = S_MKEY;
      end else begin
        cur_next   = '0;
        state_next = S_BKEY;
      end
    end

    if (scan_adv) begin
      if (cur_last) begin
        cur_next   = '0;
        state_next = (state == S_BKEY || state == S_BSCAN) ? S_HKEY : S_CLR;
      end else begin
        cur_next   = CELL_BITS'(cur + 1'b1);
        state_next = (state == S_BKEY || state == S_BSCAN) ? S_BKEY : S_HKEY;
      end
    end

    lbl_req.raddr = paddr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend       <= 1'b0;
      next_label <= LABEL_BITS'(1);
    end else begin
      state      <= state_next;
      pend       <= pend_next;
      next_label <= next_label_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt   <= cnt_next;
    cur   <= cur_next;
    paddr <= paddr_next;
    pkey  <= pkey_next;
    left  <= left_next;
    rlab  <= rlab_next;
    other <= other_next;
    mlast <= mlast_next;
    rw    <= rw_next;
    bw    <= bw_next;
    rdraw <= rdraw_next;
    bdraw <= bdraw_next;
    w     <= w_next;
    last  <= last_next;
  end

  assign idle = (state == S_IDLE);
  assign res  = '{right_walls: rw[RIGHT_BITS-1:0], bottom_walls: BOTTOM_BITS'(bw)};

endmodule

`default_nettype wire

@@ src/eller_maze_row_generator_unit.sv @@
// Top level of the maze row generator: configuration, row counter and result register.
// Usage:
//   The draw channel takes one row of wall draws per transfer; the row channel returns
//   one finished row per draw transfer, in order, with its row number and last-row flag.
//   Configuration writes (maze_width at index 0, maze_height at index 1) must be made
//   only while no row is in flight; a write takes effect with the next draw transfer.
//   One row at a time: a draw is taken only while the sequencer is idle. An inner row
//   makes a further pass for each set merge, each bottom draw and each bottom wall left
//   after the draw pass; a last row makes a further pass for each merge. The next draw
//   is taken in the cycle after the result loads; every pass walks the single-read-port
//   label memory one cell per cycle.
//   The row result sits in an output register, so the next draw transfer is accepted
//   while a finished row waits. If the receiver stalls, the following row completes and
//   then waits inside the block until the register frees up.
//   Reset clears all labels through valid bits, sets the next label to one, the row
//   counter to zero and both configuration registers to 16.
`timescale 1ns / 1ps
`default_nettype none

module eller_maze_row_generator_unit (
  input  wire                                        clk,
  input  wire                                        rst,
  input  wire                                        draw_valid,
  output logic                                       draw_ready,
  input  emrg_pkg::in_item_t                         draw,
  output logic                                       row_valid,
  input  wire                                        row_ready,
  output emrg_pkg::out_item_t                        row,
  input  wire                                        cfg_we,
  input  wire [emrg_pkg::CFG_IDX_BITS-1:0]           cfg_index,
  input  wire [emrg_pkg::CFG_DATA_BITS-1:0]          cfg_data
);
  import emrg_pkg::*;

  logic [WIDTH_BITS-1:0]  maze_width;
  logic [HEIGHT_BITS-1:0] maze_height;
  logic [ROW_BITS-1:0]    row_counter;
  logic                   last_q;
  logic [HEIGHT_BITS-1:0] h_m1;
  logic [CNT_BITS-1:0]    job_w;
  row_job_t               job;
  row_res_t               res;
  lbl_req_t               lbl_req;
  label_t                 lbl_rdata;
  logic                   seq_idle;
  logic                   res_load;
  logic                   res_ready;
  logic                   start;

  always_comb begin
    if (maze_width == '0) begin
      job_w = CNT_BITS'(1);
    end else if (32'(maze_width) > MAX_WIDTH) begin
      job_w = CNT_BITS'(MAX_WIDTH);
    end else begin
      job_w = CNT_BITS'(maze_width);
    end
  end

  assign h_m1       = (maze_height == '0) ? '0 : maze_height - 1'b1;
  assign draw_ready = seq_idle;
  assign start      = draw_valid && draw_ready;
  assign res_ready  = !row_valid || row_ready;
  assign job        = '{right_draws: draw.right_draws, bottom_draws: draw.bottom_draws,
                        width: job_w, last: (row_counter >= h_m1)};

  always_ff @(posedge clk) begin
    if (rst) begin
      maze_width  <= WIDTH_RESET;
      maze_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAZE_WIDTH: begin
          maze_width <= cfg_data[WIDTH_BITS-1:0];
        end
        REG_MAZE_HEIGHT: begin
          maze_height <= cfg_data[HEIGHT_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      row_valid   <= 1'b0;
    end else begin
      if (res_load) begin
        row_valid   <= 1'b1;
        row_counter <= last_q ? '0 : row_counter + 1'b1;
      end else if (row_ready) begin
        row_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      last_q <= job.last;
    end
    if (res_load) begin
      row <= '{right_walls: res.right_walls, bottom_walls: res.bottom_walls,
               row_number: row_counter, last_row: last_q};
    end
  end

  emrg_row_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .job       (job),
    .res_ready (res_ready),
    .idle      (seq_idle),
    .res_load  (res_load),
    .res       (res),
    .lbl_req   (lbl_req),
    .lbl_rdata (lbl_rdata)
  );

  emrg_label_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .req   (lbl_req),
    .rdata (lbl_rdata)
  );

endmodule

`default_nettype wire

@@ src/emrg_checker.sv @@
// Port-level checker of the maze row generator and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "eller_maze_row_generator_unit_macros.svh"

module emrg_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  draw_valid,
  input wire                  draw_ready,
  input wire                  row_valid,
  input wire                  row_ready,
  input emrg_pkg::out_item_t  row
);
  import emrg_pkg::*;

  // A pending row stays offered until its transfer.
  `EMRG_ASSERT_NEXT(a_row_hold, clk, rst, row_valid && !row_ready, row_valid, "row dropped before transfer")

  // After a draw transfer the block is busy building that row.
  `EMRG_ASSERT_NEXT(a_busy_after_draw, clk, rst, draw_valid && draw_ready, !draw_ready, "draw accepted while busy")

  // A last row closes the maze with a bottom wall under every cell; only the first cell's wall is checked.
  `EMRG_ASSERT_NOW(a_last_border, clk, rst, row_valid && row.last_row, row.bottom_walls[0], "last row without border")

  // A waiting row keeps its payload until its transfer.
  `EMRG_ASSERT_NEXT(a_row_stable, clk, rst, row_valid && !row_ready, $stable(row), "row changed while waiting")

endmodule

bind eller_maze_row_generator_unit emrg_checker u_chk (.*);

`default_nettype wire
